// ----- hw/rtl/sha256_message_digest_assert.svh -----
// Assertion macros for the digest block checker
`ifndef SHA256_MESSAGE_DIGEST_ASSERT_SVH
`define SHA256_MESSAGE_DIGEST_ASSERT_SVH
// implication checked every clock outside reset
`define SHD_ASSERT_IMP(lbl, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("lbl failed");
// implication whose consequent is checked on the next clock
`define SHD_ASSERT_NEXT(lbl, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("lbl failed");
`endif

// ----- hw/rtl/shd_pkg.sv -----
// Types, constants and round functions for the SHA-256 digest block
package shd_pkg;
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } shd_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } shd_out_t;

  localparam int unsigned QueueDepth = 4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_ADD, ST_PAD, ST_EMIT
  } shd_state_t;

  localparam logic [255:0] INIT_VALUE = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    return k[t];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage

// ----- hw/rtl/shd_front.sv -----
// Input stage: drops empty items and queues the rest for the core
module shd_front #(
  parameter int unsigned DEPTH = shd_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  shd_pkg::shd_in_t in_data,
  output logic            q_valid,
  input  logic            q_ready,
  output shd_pkg::shd_in_t q_data
);
  import shd_pkg::*;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  shd_in_t          mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;
  logic             push, pop, useful;

  assign useful   = in_data.byte_present | in_data.end_of_message;
  assign in_ready = (cnt_r != (AW+1)'(DEPTH)) || !useful;
  assign push     = in_valid && in_ready && useful;
  assign q_valid  = cnt_r != '0;
  assign pop      = q_valid && q_ready;
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_data;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

// ----- hw/rtl/shd_core.sv -----
// Compression core: block assembly, padding, 64 rounds, digest output
module shd_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  shd_pkg::shd_in_t q_data,
  output logic             out_valid,
  input  logic             out_ready,
  output shd_pkg::shd_out_t out_data
);
  import shd_pkg::*;

  shd_state_t   st_r, st_nxt;
  logic [31:0]  w_r [16];
  logic [31:0]  h_r [8];
  logic [31:0]  v_r [8];
  logic [60:0]  cnt_r;
  logic [5:0]   rnd_r;
  logic [2:0]   oidx_r;
  logic         closing_r;   // end seen, first padding step still pending
  logic         lenblk_r;    // current compression carries the length
  logic         padnext_r;   // length-only block follows this compression
  logic         take;

  logic [31:0] t1, t2, s0, s1, wnew;
  logic [5:0]  pos;
  logic [3:0]  wi;
  logic [1:0]  bi;

  assign pos = cnt_r[5:0];
  assign wi  = pos[5:2];
  assign bi  = pos[1:0];

  always_comb begin
    t1 = v_r[7] + (rotr(v_r[4],6) ^ rotr(v_r[4],11) ^ rotr(v_r[4],25))
         + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + round_k(rnd_r) + w_r[0];
    t2 = (rotr(v_r[0],2) ^ rotr(v_r[0],13) ^ rotr(v_r[0],22))
         + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    s0 = rotr(w_r[1],7) ^ rotr(w_r[1],18) ^ (w_r[1] >> 3);
    s1 = rotr(w_r[14],17) ^ rotr(w_r[14],19) ^ (w_r[14] >> 10);
    wnew = w_r[0] + s0 + w_r[9] + s1;
  end

  assign take = (st_r == ST_IDLE) && q_valid;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (q_valid) begin
        if (q_data.byte_present && pos == 6'd63) st_nxt = ST_LOAD;
        else if (q_data.end_of_message) st_nxt = ST_PAD;
      end
      ST_PAD:   st_nxt = ST_LOAD;
      ST_LOAD:  st_nxt = ST_ROUND;
      ST_ROUND: if (rnd_r == 6'd63) st_nxt = ST_ADD;
      ST_ADD: begin
        if (closing_r || padnext_r) st_nxt = ST_PAD;
        else if (lenblk_r) st_nxt = ST_EMIT;
        else st_nxt = ST_IDLE;
      end
      ST_EMIT:  if (out_ready && oidx_r == 3'd7) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready   = (st_r == ST_IDLE);
    out_valid = (st_r == ST_EMIT);
    out_data.digest_word = h_r[oidx_r];
    out_data.word_index  = oidx_r;
    out_data.last_word   = (oidx_r == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (take && q_data.byte_present) begin
      if (bi == 2'd0) w_r[wi] <= {q_data.data_byte, 24'd0};
      else w_r[wi][(3 - bi) * 8 +: 8] <= q_data.data_byte;
    end
    if (st_r == ST_PAD) begin
      // closing_r set: first pad step (0x80 + fill); else second, length-only block
      for (int i = 0; i < 16; i++) begin
        if (closing_r) begin
          if (i == int'(wi)) begin
            if (bi == 2'd0) w_r[i] <= {PAD_BYTE, 24'd0};
            else w_r[i][(3 - bi) * 8 +: 8] <= PAD_BYTE;
          end else if (i > int'(wi) && (i < 14 || pos >= LEN_POS)) w_r[i] <= '0;
        end else if (i < 14) w_r[i] <= '0;
      end
      if (!closing_r || pos < LEN_POS) begin
        w_r[14] <= cnt_r[60:29];
        w_r[15] <= {cnt_r[28:0], 3'd0};
      end
    end
    if (st_r == ST_LOAD) for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    if (st_r == ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= wnew;
      v_r[0] <= t1 + t2; v_r[1] <= v_r[0]; v_r[2] <= v_r[1]; v_r[3] <= v_r[2];
      v_r[4] <= v_r[3] + t1; v_r[5] <= v_r[4]; v_r[6] <= v_r[5]; v_r[7] <= v_r[6];
    end
    if (!rst_n) begin
      st_r <= ST_IDLE; cnt_r <= '0; rnd_r <= '0; oidx_r <= '0;
      closing_r <= 1'b0; lenblk_r <= 1'b0; padnext_r <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_VALUE[255 - 32 * i -: 32];
    end else begin
      st_r <= st_nxt;
      if (take) begin
        if (q_data.byte_present) cnt_r <= cnt_r + 1'b1;
        closing_r <= q_data.end_of_message;
        lenblk_r  <= 1'b0;
        padnext_r <= 1'b0;
      end
      if (st_r == ST_PAD) begin
        closing_r <= 1'b0;
        lenblk_r  <= !closing_r || pos < LEN_POS;
        padnext_r <= closing_r && pos >= LEN_POS;
      end
      if (st_r == ST_ROUND) rnd_r <= rnd_r + 1'b1;
      if (st_r == ST_ADD)
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      if (st_r == ST_EMIT && out_ready) begin
        oidx_r <= oidx_r + 1'b1;
        if (oidx_r == 3'd7) begin
          cnt_r <= '0;
          for (int i = 0; i < 8; i++) h_r[i] <= INIT_VALUE[255 - 32 * i -: 32];
        end
      end
    end
  end
endmodule

// ----- hw/rtl/sha256_message_digest.sv -----
// SHA-256 over a byte stream: a 4-entry input queue feeds a one-round-per-cycle core.
// The 64th byte of a block starts a compression, during which the core takes no items.
// An end item costs 1 or 2 compressions plus 8 digest transfers.
// The queue lets up to 4 non-empty items be taken while the core compresses.
// rst_n is synchronous: queue empties, hash state reloads the initial value, count clears.
module sha256_message_digest #(
  parameter int unsigned QUEUE_DEPTH = shd_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  shd_pkg::shd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output shd_pkg::shd_out_t out_data
);
  import shd_pkg::*;
  shd_in_t q_data;
  logic    q_valid, q_ready;

  shd_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .q_valid, .q_ready, .q_data);
  shd_core u_core (
    .clk, .rst_n, .q_valid, .q_ready, .q_data, .out_valid, .out_ready, .out_data);
endmodule

// ----- hw/rtl/shd_checker.sv -----
// Port-level checker for the digest block, bound to the top level
`include "sha256_message_digest_assert.svh"
module shd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input shd_pkg::shd_out_t out_data
);
  import shd_pkg::*;
  `SHD_ASSERT_IMP(a_last_idx, rst_n, out_valid, out_data.last_word == (out_data.word_index == 3'd7))
  `SHD_ASSERT_NEXT(a_idx_step, rst_n, out_valid && out_ready && !out_data.last_word,
    out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
  `SHD_ASSERT_NEXT(a_hold, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind sha256_message_digest shd_checker u_shd_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_data);

// ----- bench/sha256_digest_checker.sv -----
// Checker for the SHA-256 digest block: predicts digests and compares results
module sha256_digest_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  shd_pkg::shd_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  shd_pkg::shd_out_t out_data,
  output int                fail_count,
  output int                pending_words
);
  timeunit 1ns;
  timeprecision 1ps;
  import shd_pkg::*;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  logic [31:0] chain [8];
  logic [31:0] msg_block [16];
  logic [60:0] msg_bytes;
  shd_out_t    digest_q [$];

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++) w[t] = msg_block[t];
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + w[t-7]
           + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
           + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
    v = chain;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic place_byte(int pos, logic [7:0] b);
    if (pos[1:0] == 0) msg_block[pos >> 2] = '0;
    msg_block[pos >> 2][(3 - pos[1:0]) * 8 +: 8] = b;
  endtask

  task automatic restart();
    for (int i = 0; i < 8; i++) chain[i] = INIT_VALUE[255 - 32*i -: 32];
    msg_bytes = '0;
  endtask

  task automatic absorb(shd_in_t it);
    int pos;
    logic [63:0] bit_len;
    shd_out_t o;
    if (it.byte_present) begin
      pos = msg_bytes[5:0];
      place_byte(pos, it.data_byte);
      msg_bytes++;
      if (pos == 63) compress_block();
    end
    if (!it.end_of_message) return;
    pos = msg_bytes[5:0];
    place_byte(pos, PAD_BYTE);
    for (int i = (pos >> 2) + 1; i < 16; i++) msg_block[i] = '0;
    if (pos >= LEN_POS) begin
      compress_block();
      for (int i = 0; i < 16; i++) msg_block[i] = '0;
    end
    bit_len = {msg_bytes, 3'b000};
    msg_block[14] = bit_len[63:32];
    msg_block[15] = bit_len[31:0];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      o.digest_word = chain[i];
      o.word_index  = i[2:0];
      o.last_word   = (i == 7);
      digest_q.push_back(o);
    end
    restart();
  endtask

  initial begin
    fail_count = 0;
    restart();
  end

  always @(posedge clk) begin
    shd_out_t want;
    if (!rst_n) begin
      restart();
      digest_q.delete();
    end else begin
      if (in_valid && in_ready) absorb(in_data);
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected digest transfer %h", out_data);
        end else begin
          want = digest_q.pop_front();
          if (out_data !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("digest mismatch: exp word %h idx %0d last %b, got %h idx %0d last %b",
                       want.digest_word, want.word_index, want.last_word,
                       out_data.digest_word, out_data.word_index, out_data.last_word);
          end
        end
      end
    end
    pending_words = digest_q.size();
  end
endmodule

// ----- bench/tb_sha256_message_digest.sv -----
// Testbench top for the SHA-256 digest block: stimulus, back-pressure and verdict
module tb_sha256_message_digest;
  timeunit 1ns;
  timeprecision 1ps;
  import shd_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  shd_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  shd_out_t out_data;
  int       fail_count;
  int       pending_words;
  int       idle_cycles = 0;
  int       stall_left = 0;

  always #1 clk = ~clk;

  sha256_message_digest dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
  );

  sha256_digest_checker checker_i (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .fail_count, .pending_words
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 80));
  endfunction

  // one transfer on the input channel, with an optional gap before it
  task automatic send(logic [7:0] b, logic present, logic last, bit gaps);
    int gap;
    gap = gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= '{data_byte: b, byte_present: present, end_of_message: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and hold off until every expected digest word has come
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  task automatic send_message(int len, int last_mode, bit gaps);
    // last_mode 0: bare end marker, 1: last byte carries end
    for (int i = 0; i < len - (last_mode ? 1 : 0); i++) begin
      // occasional filler item with neither flag
      if ($urandom_range(0, 19) == 0) send(8'($urandom), 1'b0, 1'b0, gaps);
      send(8'($urandom), 1'b1, 1'b0, gaps);
    end
    if (last_mode && len > 0) send(8'($urandom), 1'b1, 1'b1, gaps);
    else send(8'($urandom), 1'b0, 1'b1, gaps);
  endtask

  // receiver stalls: mostly single cycles, now and then a long one
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 15) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap();
    end else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("[sha256_message_digest] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: empty messages, extreme bytes, byte+end, a filler item, bare end marker
    send(8'h00, 1'b0, 1'b1, 1'b0);
    send(8'hff, 1'b0, 1'b1, 1'b0);
    send(8'hff, 1'b1, 1'b1, 1'b0);
    send(8'h00, 1'b1, 1'b0, 1'b0);
    send(8'h5a, 1'b0, 1'b0, 1'b0);
    send(8'h61, 1'b1, 1'b1, 1'b0);
    send(8'haa, 1'b1, 1'b0, 1'b0);
    send(8'h55, 1'b1, 1'b0, 1'b0);
    send(8'h00, 1'b0, 1'b1, 1'b0);
    // sender holds off until all digests are back
    drain();
    // end at byte 57 needs a second padding block; 64th byte with end closes a full block
    send_message(57, 1, 1'b0);
    send_message(64, 1, 1'b1);
    // random short messages
    for (int n = 0; n < 8; n++) begin
      send_message(int'($urandom_range(0, 10)), int'($urandom_range(0, 1)), 1'b1);
      if (n == 3) drain();
    end
    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("[sha256_message_digest] OK");
    else $display("[sha256_message_digest] ERROR");
    $finish;
  end
endmodule
